// File: rtl/htld_pkg.sv
// Package for the hex triplet line deframer.
// Holds character codes, field widths, parameter defaults and the hex digit decoder.
// No dependencies.
`timescale 1ns / 1ps

package htld_pkg;

  localparam int LINE_LIMIT_DEF   = 384;
  localparam int MAX_TRIPLETS_DEF = 64;

  localparam int CHUNK_CHARS = 6;
  localparam int CMD_W       = 8;
  localparam int ZONE_W      = 5;
  localparam int DATA_W      = 8;
  localparam int TRIPLET_W   = CMD_W + ZONE_W + DATA_W;
  localparam int OUT_TDATA_W = ((TRIPLET_W + 7) / 8) * 8;

  localparam logic [7:0] CHAR_LF        = 8'h0A;
  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam logic [7:0] CHAR_PRINT_LO  = 8'h20;
  localparam logic [7:0] CHAR_PRINT_HI  = 8'h7E;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_digit_t;

  // Decode one ASCII hex digit, either case.
  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    r.ok  = 1'b1;
    r.nib = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.nib = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.nib = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.nib = 4'(c - 8'h57);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

// File: rtl/hex_triplet_line_deframer.sv
// Top level of the hex triplet line deframer: line assembly, triplet store, drain.
// Depends on htld_pkg.
`timescale 1ns / 1ps

// Takes one received byte per cycle while idle. CR or LF closes a line; printable
// bytes are gathered into six-character chunks and every all-hex chunk, up to
// MAX_TRIPLETS per line, is kept in an on-chip triplet memory (command, zone low
// five bits, data). When a non-empty line closes, the kept triplets stream out in
// arrival order, the final one with tlast set. The read of the first triplet is
// primed as the line end is taken, and each taken triplet moves the single read
// port of the triplet memory on to the next; input is held off during the drain.
// A printable byte beyond LINE_LIMIT characters in a line is dropped with all that
// the line gathered, and gathering starts afresh. The memory needs no clearing
// after reset, since only entries written in the current line are ever sent out.
module hex_triplet_line_deframer
  import htld_pkg::*;
#(
  parameter int LINE_LIMIT   = LINE_LIMIT_DEF,
  parameter int MAX_TRIPLETS = MAX_TRIPLETS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // rx_byte[7:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // command_code[7:0], zone_number[12:8],
                                             // data_value[20:13], zero pad above
  output logic                   out_tlast   // last_of_line
);

  localparam int LEN_W = $clog2(LINE_LIMIT + 1);
  localparam int CNT_W = $clog2(MAX_TRIPLETS + 1);
  localparam int IDX_W = (MAX_TRIPLETS > 1) ? $clog2(MAX_TRIPLETS) : 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SHOW = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [LEN_W-1:0] line_len_r, line_len_nxt;
  logic [2:0]       pos_r, pos_nxt;
  logic [23:0]      asm_r, asm_nxt;
  logic             all_hex_r, all_hex_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;

  logic [TRIPLET_W-1:0] store_mem [MAX_TRIPLETS];
  logic [TRIPLET_W-1:0] mem_q_r;
  logic [IDX_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [TRIPLET_W-1:0] wr_data;

  logic       in_acc, out_acc, is_eol, is_print, is_last;
  hex_digit_t hd;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_SHOW);
  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_tvalid && out_tready;
  assign is_eol     = (in_tdata == CHAR_CR) || (in_tdata == CHAR_LF);
  assign is_print   = (in_tdata >= CHAR_PRINT_LO) && (in_tdata <= CHAR_PRINT_HI);
  assign hd         = hex_decode(in_tdata);
  assign is_last    = ({{(CNT_W - IDX_W){1'b0}}, rd_idx_r} + CNT_W'(1)) == count_r;

  assign out_tdata  = {{(OUT_TDATA_W - TRIPLET_W){1'b0}}, mem_q_r};
  assign out_tlast  = is_last;

  always_comb begin
    state_nxt    = state_r;
    line_len_nxt = line_len_r;
    pos_nxt      = pos_r;
    asm_nxt      = asm_r;
    all_hex_nxt  = all_hex_r;
    count_nxt    = count_r;
    rd_idx_nxt   = rd_idx_r;
    rd_addr      = rd_idx_r;
    wr_en        = 1'b0;
    wr_data      = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc && is_eol) begin
          if (line_len_r != '0) begin
            if (count_r != '0) begin
              // prime the read of the first triplet
              rd_idx_nxt = '0;
              rd_addr    = '0;
              state_nxt  = S_SHOW;
            end else begin
              line_len_nxt = '0;
              pos_nxt      = '0;
              asm_nxt      = '0;
              all_hex_nxt  = 1'b1;
            end
          end
        end else if (in_acc && is_print) begin
          if (line_len_r == LEN_W'(LINE_LIMIT)) begin
            // overlong: drop everything this line gathered so far
            line_len_nxt = '0;
            count_nxt    = '0;
            pos_nxt      = '0;
            asm_nxt      = '0;
            all_hex_nxt  = 1'b1;
          end else begin
            line_len_nxt = line_len_r + LEN_W'(1);
            if (hd.ok) begin
              asm_nxt = {asm_r[19:0], hd.nib};
            end else begin
              all_hex_nxt = 1'b0;
            end
            pos_nxt = pos_r + 3'd1;
            if (pos_r == 3'(CHUNK_CHARS - 1)) begin
              if (all_hex_nxt && (count_r < CNT_W'(MAX_TRIPLETS))) begin
                wr_en     = 1'b1;
                wr_data   = {asm_nxt[7:0], asm_nxt[12:8], asm_nxt[23:16]};
                count_nxt = count_r + CNT_W'(1);
              end
              pos_nxt     = '0;
              asm_nxt     = '0;
              all_hex_nxt = 1'b1;
            end
          end
        end
      end
      S_SHOW: begin
        if (out_acc) begin
          if (is_last) begin
            state_nxt    = S_IDLE;
            line_len_nxt = '0;
            count_nxt    = '0;
            pos_nxt      = '0;
            asm_nxt      = '0;
            all_hex_nxt  = 1'b1;
          end else begin
            // advance: next entry lands in the read register at this edge
            rd_idx_nxt = rd_idx_r + IDX_W'(1);
            rd_addr    = rd_idx_nxt;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      line_len_r <= '0;
      pos_r      <= '0;
      asm_r      <= '0;
      all_hex_r  <= 1'b1;
      count_r    <= '0;
      rd_idx_r   <= '0;
    end else begin
      state_r    <= state_nxt;
      line_len_r <= line_len_nxt;
      pos_r      <= pos_nxt;
      asm_r      <= asm_nxt;
      all_hex_r  <= all_hex_nxt;
      count_r    <= count_nxt;
      rd_idx_r   <= rd_idx_nxt;
    end
  end

  // triplet memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[count_r[IDX_W-1:0]] <= wr_data;
    end
    mem_q_r <= store_mem[rd_addr];
  end

  a_no_input_during_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input accepted while triplets drain");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_TRIPLETS))
    else $error("triplet count beyond store depth");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    line_len_r <= LEN_W'(LINE_LIMIT))
    else $error("line length beyond limit");

  a_drain_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !out_tlast) |=> (out_tvalid && count_r == $past(count_r)))
    else $error("drain stopped before the last triplet");

  a_drain_ends_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_tlast) |=> (count_r == '0 && line_len_r == '0 && in_tready))
    else $error("line state not cleared after drain");

endmodule

// File: tb/sv/htld_triplet_check.sv
// Triplet checker for the hex triplet line deframer: watches both streams,
// works out the triplets each accepted byte releases and compares them in order.
// Depends on htld_pkg.
`timescale 1ns / 1ps

module htld_triplet_check
  import htld_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [7:0]             in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tlast,
  output int                     fail_count,
  output int                     triplets_pending
);

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ZONE_W-1:0] zone;
    logic [DATA_W-1:0] data;
    logic              flag_last;
  } triplet_t;

  logic [8:0]  line_len;
  logic [2:0]  chunk_pos;
  logic [23:0] chunk_acc;
  logic        chunk_hex;
  logic [6:0]  kept_cnt;
  triplet_t    kept [MAX_TRIPLETS_DEF];
  triplet_t    triplets_due [$];
  triplet_t    due_t;

  initial begin
    fail_count       = 0;
    triplets_pending = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  task automatic clear_line();
    line_len  = '0;
    kept_cnt  = '0;
    chunk_pos = '0;
    chunk_acc = '0;
    chunk_hex = 1'b1;
  endtask

  // Advance the line state by one received byte; queue the triplets a line end releases.
  task automatic deframe_byte(input logic [7:0] b);
    logic [3:0] nib;
    logic       is_hex;
    int         k;
    triplet_t   t;
    if (b == CHAR_CR || b == CHAR_LF) begin
      if (line_len != 0) begin
        for (k = 0; k < kept_cnt; k++) begin
          t           = kept[k];
          t.flag_last = (k == kept_cnt - 1);
          triplets_due.push_back(t);
        end
        clear_line();
      end
    end else if (b >= CHAR_PRINT_LO && b <= CHAR_PRINT_HI) begin
      line_len = line_len + 1'b1;
      if (line_len > LINE_LIMIT_DEF) begin
        // drop what the line gathered, this character with it
        clear_line();
      end else begin
        is_hex = 1'b1;
        nib    = 4'h0;
        if (b >= "0" && b <= "9") begin
          nib = 4'(b - "0");
        end else if (b >= "A" && b <= "F") begin
          nib = 4'(b - "A" + 10);
        end else if (b >= "a" && b <= "f") begin
          nib = 4'(b - "a" + 10);
        end else begin
          is_hex = 1'b0;
        end
        if (is_hex) begin
          chunk_acc = {chunk_acc[19:0], nib};
        end else begin
          chunk_hex = 1'b0;
        end
        chunk_pos = chunk_pos + 1'b1;
        if (chunk_pos == CHUNK_CHARS) begin
          if (chunk_hex && kept_cnt < MAX_TRIPLETS_DEF) begin
            t.cmd          = chunk_acc[23:16];
            t.zone         = chunk_acc[12:8];
            t.data         = chunk_acc[7:0];
            t.flag_last    = 1'b0;
            kept[kept_cnt] = t;
            kept_cnt       = kept_cnt + 1'b1;
          end
          chunk_pos = '0;
          chunk_acc = '0;
          chunk_hex = 1'b1;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_line();
      triplets_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (triplets_due.size() == 0) begin
          report_mismatch($sformatf("triplet %h with none outstanding", out_tdata));
        end else begin
          due_t = triplets_due.pop_front();
          if (out_tdata[7:0] !== due_t.cmd)
            report_mismatch($sformatf("command %h, want %h", out_tdata[7:0], due_t.cmd));
          if (out_tdata[12:8] !== due_t.zone)
            report_mismatch($sformatf("zone %h, want %h", out_tdata[12:8], due_t.zone));
          if (out_tdata[20:13] !== due_t.data)
            report_mismatch($sformatf("data %h, want %h", out_tdata[20:13], due_t.data));
          if (out_tdata[OUT_TDATA_W-1:TRIPLET_W] !== '0)
            report_mismatch($sformatf("pad bits set in %h", out_tdata));
          if (out_tlast !== due_t.flag_last)
            report_mismatch($sformatf("tlast %b, want %b", out_tlast, due_t.flag_last));
        end
      end
      if (in_tvalid && in_tready) begin
        deframe_byte(in_tdata);
      end
    end
    triplets_pending = triplets_due.size();
  end

endmodule

// File: tb/sv/tb_hex_triplet_line_deframer.sv
// Top of the hex triplet line deframer bench: clock, reset, byte and result drivers.
// Depends on htld_pkg, hex_triplet_line_deframer and htld_triplet_check.
`timescale 1ns / 1ps

module tb_hex_triplet_line_deframer;
  import htld_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 40;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata   = 8'h00;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  int fail_count;
  int triplets_pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int bytes_sent     = 0;
  int hold_req       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int cycle_count    = 0;
  int phase;
  int target;

  always #1 clk = ~clk;

  hex_triplet_line_deframer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  htld_triplet_check u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .fail_count      (fail_count),
    .triplets_pending(triplets_pending)
  );

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[hex_triplet_line_deframer] ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'("0" + v);
    return $urandom_range(0, 1) ? 8'("A" + v - 10) : 8'("a" + v - 10);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    // ignored control bytes do not count towards the item budget
    if (b == CHAR_CR || b == CHAR_LF || (b >= CHAR_PRINT_LO && b <= CHAR_PRINT_HI))
      bytes_sent++;
  endtask

  task automatic send_string(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_hex_run(input int n);
    repeat (n) send_byte(hex_char());
  endtask

  // Mostly well-formed lines of hex chunks; some noise, broken chunks and stray bytes.
  task automatic send_random_line();
    int         nchunks;
    int         bad_at;
    int         i;
    int         j;
    logic [7:0] c;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 16)) send_byte(8'($urandom_range(0, 255)));
      return;
    end
    nchunks = ($urandom_range(0, 11) == 0) ? $urandom_range(8, 64) : $urandom_range(0, 5);
    for (i = 0; i < nchunks; i++) begin
      bad_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 5) : -1;
      for (j = 0; j < CHUNK_CHARS; j++) begin
        if ($urandom_range(0, 15) == 0) begin
          do c = 8'($urandom_range(0, 255));
          while ((c >= CHAR_PRINT_LO && c <= CHAR_PRINT_HI) || c == CHAR_CR || c == CHAR_LF);
          send_byte(c);
        end
        if (j == bad_at) begin
          do c = 8'($urandom_range(CHAR_PRINT_LO, CHAR_PRINT_HI));
          while ((c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f"));
          send_byte(c);
        end else begin
          send_byte(hex_char());
        end
      end
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(CHAR_PRINT_LO, CHAR_PRINT_HI)));
    send_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
    if ($urandom_range(0, 4) == 0) send_byte(CHAR_LF);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      if (phase == 0) begin
        send_byte(CHAR_LF);                 // line end with nothing gathered
        send_string("fFFfFf09a0AF");        // all-ones fields, then a zone masked to zero
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_string(" ~");                  // trailing partial chunk of printable extremes
        send_byte(CHAR_LF);
        send_string("G12345");              // line with no valid chunk
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        // full store; hold the receiver while the block drains and stalls input
        send_hex_run(LINE_LIMIT_DEF);
        hold_req++;
        send_byte(CHAR_CR);
        send_string("123456");
        send_byte(CHAR_LF);
        // overlong line is dropped, the rest starts afresh
        send_hex_run(LINE_LIMIT_DEF + 6);
        send_byte(CHAR_LF);
        send_string("abcdef");
        send_byte(CHAR_CR);
      end
      target = bytes_sent + 65;
      while (bytes_sent < target) send_random_line();
    end
    in_tvalid <= 1'b0;

    wait (triplets_pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && triplets_pending == 0) begin
      $display("[hex_triplet_line_deframer] OK");
    end else begin
      $display("[hex_triplet_line_deframer] ERROR");
    end
    $finish;
  end

endmodule
